// ===== rtl/uripe_pkg.sv =====
`timescale 1ns / 1ps

package uripe_pkg;

    // character set selector codes
    localparam logic [1:0] CS_URI       = 2'd0;
    localparam logic [1:0] CS_PERCENT   = 2'd1;
    localparam logic [1:0] CS_COMPONENT = 2'd2;

    // register word index
    localparam logic REG_CHAR_SET = 1'b0;
    localparam logic [1:0] CHAR_SET_RESET = CS_PERCENT;

    // escape phase codes
    localparam logic [1:0] PH_PCT = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;

    // characters of interest
    localparam logic [7:0] CHAR_PCT    = 8'h25;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;

    // code point limits
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_ONE_LIM  = 21'h000080;
    localparam logic [20:0] CP_TWO_LIM  = 21'h000800;
    localparam logic [20:0] CP_THREE_LIM = 21'h010000;

    // one encoded item waiting for the serialiser
    typedef struct packed {
        logic            lit;
        logic [2:0]      nb;
        logic [3:0][7:0] bytes;
    } t_enc_item;

    // uppercase hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // true when an ascii character passes unescaped under the given set
    function automatic logic char_allowed(input logic [6:0] c7, input logic [1:0] sel);
        logic [7:0] c;
        logic       alnum;
        logic       mark;
        logic       resv;
        logic       extra;
        c     = {1'b0, c7};
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A);
        mark  = 1'b0;
        resv  = 1'b0;
        case (c) inside
            8'h2D, 8'h5F, 8'h2E, 8'h21, CHAR_TILDE, 8'h2A, CHAR_QUOTE, 8'h28, 8'h29:
                mark = 1'b1;
            8'h3B, 8'h2C, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24,
            CHAR_HASH:
                resv = 1'b1;
            default: begin
                mark = 1'b0;
                resv = 1'b0;
            end
        endcase
        extra = (c == CHAR_LBRACK) || (c == CHAR_RBRACK) || (c == CHAR_PCT);
        if (alnum || mark) begin
            return 1'b1;
        end else if (sel == CS_URI) begin
            return resv;
        end else if (sel == CS_PERCENT) begin
            return resv || extra;
        end
        return 1'b0;
    endfunction

endpackage

// ===== rtl/uri_percent_encoder_unit.sv =====
`timescale 1ns / 1ps
// path: an item goes through the input, encode and serialiser stages and the output register
// throughput: one output byte per cycle from the serialiser; a literal item is one byte, an
//   escaped item is a percent sign and two hex digits for each of its bytes; items with no
//   output leave the pipe at the encode stage and never reach the serialiser
// reset: synchronous active low; clears the stage valid bits, the strobe and sets char_set to 1
// the receiver cannot stall: one strobe per byte, start is held off through busy
module uri_percent_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [20:0] i_code_point,
    output logic        o_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uripe_pkg::*;

    logic [1:0]  r_char_set;

    logic        r1_valid;
    logic [20:0] r1_cp;

    logic        r2_valid;
    t_enc_item   r2_item;

    logic        r3_valid;
    t_enc_item   r3_item;
    logic [1:0]  r3_phase;
    logic [1:0]  r3_bidx;

    logic        r_o_strobe;
    logic [7:0]  r_o_char;
    logic        r_o_last;

    logic        s3_last;
    logic        s3_free;
    logic        s2_open;
    logic        s1_open;
    logic        accept;

    logic        enc_fail;
    t_enc_item   n_r2_item;
    logic [7:0]  cur_byte;
    logic [7:0]  cur_char;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHAR_SET) ? {30'd0, r_char_set} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_set <= CHAR_SET_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHAR_SET) begin
            r_char_set <= pwdata[1:0];
        end
    end

    // stage flow control
    assign s3_last = r3_valid && (r3_item.lit ||
                     (r3_phase == PH_LO && r3_bidx == 2'(r3_item.nb - 3'd1)));
    assign s3_free = !r3_valid || s3_last;
    assign s2_open = !r2_valid || s3_free;
    assign s1_open = !r1_valid || s2_open;
    assign busy    = !s1_open;
    assign accept  = start && !busy;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_open) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_open) begin
            r1_cp <= i_code_point;
        end
    end

    // classify and utf-8 encode
    always_comb begin
        enc_fail        = (r1_cp == 21'd0) || (r1_cp > CP_MAX) ||
                          (r1_cp >= CP_SURR_LO && r1_cp <= CP_SURR_HI);
        n_r2_item       = '0;
        if (r1_cp < CP_ONE_LIM) begin
            n_r2_item.lit      = char_allowed(r1_cp[6:0], r_char_set);
            n_r2_item.nb       = 3'd1;
            n_r2_item.bytes[0] = {1'b0, r1_cp[6:0]};
        end else if (r1_cp < CP_TWO_LIM) begin
            n_r2_item.nb       = 3'd2;
            n_r2_item.bytes[0] = {3'b110, r1_cp[10:6]};
            n_r2_item.bytes[1] = {2'b10, r1_cp[5:0]};
        end else if (r1_cp < CP_THREE_LIM) begin
            n_r2_item.nb       = 3'd3;
            n_r2_item.bytes[0] = {4'b1110, r1_cp[15:12]};
            n_r2_item.bytes[1] = {2'b10, r1_cp[11:6]};
            n_r2_item.bytes[2] = {2'b10, r1_cp[5:0]};
        end else begin
            n_r2_item.nb       = 3'd4;
            n_r2_item.bytes[0] = {5'b11110, r1_cp[20:18]};
            n_r2_item.bytes[1] = {2'b10, r1_cp[17:12]};
            n_r2_item.bytes[2] = {2'b10, r1_cp[11:6]};
            n_r2_item.bytes[3] = {2'b10, r1_cp[5:0]};
        end
    end

    // encode stage, items with no output are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_open) begin
            r2_valid <= r1_valid && !enc_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_open) begin
            r2_item <= n_r2_item;
        end
    end

    // serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_phase <= PH_PCT;
            r3_bidx  <= 2'd0;
        end else if (s3_free) begin
            r3_valid <= r2_valid;
            r3_phase <= PH_PCT;
            r3_bidx  <= 2'd0;
        end else if (r3_phase == PH_LO) begin
            r3_phase <= PH_PCT;
            r3_bidx  <= r3_bidx + 2'd1;
        end else begin
            r3_phase <= r3_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r3_item <= r2_item;
        end
    end

    // current output character
    always_comb begin
        cur_byte = r3_item.bytes[r3_bidx];
        if (r3_item.lit) begin
            cur_char = cur_byte;
        end else begin
            case (r3_phase)
                PH_PCT:  cur_char = CHAR_PCT;
                PH_HI:   cur_char = hex_char(cur_byte[7:4]);
                default: cur_char = hex_char(cur_byte[3:0]);
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_char <= cur_char;
        r_o_last <= s3_last;
    end

    assign o_strobe      = r_o_strobe;
    assign o_out_char    = r_o_char;
    assign o_last_of_run = r_o_strobe && r_o_last;

    // checks
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r1_valid)
        else $error("accepted item not in input stage");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r1_valid && r2_valid && r3_valid))
        else $error("busy with a free stage");

    a_ser_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |=> o_strobe)
        else $error("serialiser byte lost");

    a_escape_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && !r3_item.lit && r3_phase == PH_PCT) |=> (o_out_char == CHAR_PCT))
        else $error("escape does not open with percent");

    a_bidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> ({1'b0, r3_bidx} < r3_item.nb))
        else $error("byte index beyond encoded length");

endmodule
